### rtl/ckf_pkg.sv
// ----------------------------------------------------------------------------
// ckf_pkg: shared types and constants of the key token filter
// key text, character codes, field widths and the held-row control bundle
// ----------------------------------------------------------------------------
package ckf_pkg;

    localparam int KEY_LENGTH   = 13;
    localparam int HELD_DEPTH   = KEY_LENGTH - 1;
    localparam int KCNT_W       = $clog2(KEY_LENGTH);
    localparam int IDX_W        = $clog2(HELD_DEPTH);
    localparam int MAX_CAPACITY = 1024;
    localparam int CAP_W        = 11;
    localparam int LEN_W        = 10;
    localparam int BYTE_W       = 8;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    // "tpm.baseline="
    localparam logic [BYTE_W-1:0] KEY_TEXT [KEY_LENGTH] = '{
        8'h74, 8'h70, 8'h6d, 8'h2e, 8'h62, 8'h61, 8'h73,
        8'h65, 8'h6c, 8'h69, 8'h6e, 8'h65, 8'h3d
    };

    // control of the held-byte row
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] idx;
        logic             shift;
    } held_ctrl_t;

endpackage

### rtl/ckf_cell.sv
// ----------------------------------------------------------------------------
// ckf_cell: one held-byte cell
// loads a byte at its own slot or takes the byte of its upper neighbor
// ----------------------------------------------------------------------------
module ckf_cell (
    input  logic                      aclk,
    input  logic                      load,
    input  logic [ckf_pkg::BYTE_W-1:0] load_data,
    input  logic                      shift,
    input  logic [ckf_pkg::BYTE_W-1:0] shift_in,
    output logic [ckf_pkg::BYTE_W-1:0] q
);

    logic [ckf_pkg::BYTE_W-1:0] data_reg;
    logic [ckf_pkg::BYTE_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (load) begin
            data_next = load_data;
        end else if (shift) begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### rtl/ckf_held_row.sv
// ----------------------------------------------------------------------------
// ckf_held_row: row of cells holding a possible key prefix
// bytes enter at their index; while shift is set they drain one a cycle from cell zero
// ----------------------------------------------------------------------------
module ckf_held_row (
    input  logic                       aclk,
    input  ckf_pkg::held_ctrl_t        ctrl,
    input  logic [ckf_pkg::BYTE_W-1:0] load_data,
    output logic [ckf_pkg::BYTE_W-1:0] head_byte
);

    logic [ckf_pkg::BYTE_W-1:0] cell_q [ckf_pkg::HELD_DEPTH];

    for (genvar i = 0; i < ckf_pkg::HELD_DEPTH; i++) begin : g_cell
        logic [ckf_pkg::BYTE_W-1:0] upper;
        if (i == ckf_pkg::HELD_DEPTH - 1) begin : g_top
            assign upper = ckf_pkg::CHAR_NUL;
        end else begin : g_mid
            assign upper = cell_q[i+1];
        end

        ckf_cell u_cell (
            .aclk      (aclk),
            .load      (ctrl.load && (ctrl.idx == ckf_pkg::IDX_W'(i))),
            .load_data (load_data),
            .shift     (ctrl.shift),
            .shift_in  (upper),
            .q         (cell_q[i])
        );
    end

    assign head_byte = cell_q[0];

endmodule

### rtl/cmdline_key_token_filter.sv
// ----------------------------------------------------------------------------
// cmdline_key_token_filter: drops "tpm.baseline=" tokens from a command line
// whitespace-normalizing token filter with held-prefix release
// ----------------------------------------------------------------------------
// One input word is one byte of a command line; a zero byte ends the line.
// Tokens split by space or tab are sent out joined by single spaces, except
// tokens starting with the key "tpm.baseline=", which are dropped. While a
// token still matches the key its bytes sit in a row of 12 cells and are
// released (after a separating space) once the token departs from the key
// or ends early. At most capacity-1 bytes go out per line; the zero byte
// gives an end word with the final length and the truncation flag, and
// m_tlast marks the last word caused by each input byte. A byte that
// gives no word leaves the input ready; one that gives words holds s_tready
// low until its emission plan is done, as a sequencer sends one word per
// cycle and the held row drains one cell per cycle while the output is free.
// cfg_wdata may be written only while the block is idle;
// zero counts as one and values above 1024 count as 1024.
// ----------------------------------------------------------------------------
module cmdline_key_token_filter (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: capacity
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [17:8] out_length,
                                   // [18] truncated, [23:19] zero
    output logic        m_tuser,   // [0] is_end
    output logic        m_tlast    // last_of_run
);

    typedef enum logic [1:0] {
        PH_BETWEEN,
        PH_HOLD,
        PH_PASS,
        PH_DROP
    } phase_t;

    localparam int PAD_W = 24 - ckf_pkg::BYTE_W - ckf_pkg::LEN_W - 1;

    // token state
    phase_t                       phase_reg, phase_next;
    logic [ckf_pkg::KCNT_W-1:0]   kcnt_reg, kcnt_next;
    logic [ckf_pkg::LEN_W-1:0]    written_reg, written_next;
    logic [ckf_pkg::CAP_W-1:0]    cap_reg, cap_next;

    // pending emission plan
    logic                         space_pend_reg, space_pend_next;
    logic [ckf_pkg::KCNT_W-1:0]   rel_cnt_reg, rel_cnt_next;
    logic                         tail_byte_pend_reg, tail_byte_pend_next;
    logic                         tail_end_pend_reg, tail_end_pend_next;
    logic [ckf_pkg::BYTE_W-1:0]   tail_byte_reg, tail_byte_next;

    // output word register
    logic                         m_valid_reg, m_valid_next;
    logic [ckf_pkg::BYTE_W-1:0]   m_byte_reg, m_byte_next;
    logic [ckf_pkg::LEN_W-1:0]    m_len_reg, m_len_next;
    logic                         m_trunc_reg, m_trunc_next;
    logic                         m_end_reg, m_end_next;
    logic                         m_last_reg, m_last_next;

    ckf_pkg::held_ctrl_t          held_ctrl;
    logic [ckf_pkg::BYTE_W-1:0]   head_byte;

    logic busy, out_free, s_fire, step_fire, room, trunc_after, trunc_now;
    logic is_ws, key_hit, byte_step, rem_after;
    logic [ckf_pkg::BYTE_W-1:0] step_byte;
    logic [ckf_pkg::CAP_W-1:0]  written_ext;

    // held prefix row
    ckf_held_row u_held_row (
        .aclk      (aclk),
        .ctrl      (held_ctrl),
        .load_data (s_tdata),
        .head_byte (head_byte)
    );

    assign busy      = space_pend_reg || (rel_cnt_reg != '0) || tail_byte_pend_reg
                       || tail_end_pend_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = !busy;
    assign s_fire    = s_tvalid && s_tready;
    assign step_fire = busy && out_free;

    // room checks against the effective capacity
    assign written_ext = ckf_pkg::CAP_W'(written_reg);
    assign room        = (written_ext + ckf_pkg::CAP_W'(1)) < cap_reg;
    assign trunc_after = (written_ext + ckf_pkg::CAP_W'(2)) == cap_reg;
    assign trunc_now   = (written_ext + ckf_pkg::CAP_W'(1)) == cap_reg;

    assign is_ws   = (s_tdata == ckf_pkg::CHAR_SPACE) || (s_tdata == ckf_pkg::CHAR_TAB);
    assign key_hit = (s_tdata == ckf_pkg::KEY_TEXT[kcnt_reg]);

    // byte steps run in order: space, held bytes, then the current byte
    assign byte_step = space_pend_reg || (rel_cnt_reg != '0) || tail_byte_pend_reg;

    always_comb begin
        if (space_pend_reg) begin
            step_byte = ckf_pkg::CHAR_SPACE;
        end else if (rel_cnt_reg != '0) begin
            step_byte = head_byte;
        end else begin
            step_byte = tail_byte_reg;
        end
    end

    always_comb begin
        phase_next          = phase_reg;
        kcnt_next           = kcnt_reg;
        written_next        = written_reg;
        cap_next            = cap_reg;
        space_pend_next     = space_pend_reg;
        rel_cnt_next        = rel_cnt_reg;
        tail_byte_pend_next = tail_byte_pend_reg;
        tail_end_pend_next  = tail_end_pend_reg;
        tail_byte_next      = tail_byte_reg;
        m_valid_next        = m_valid_reg;
        m_byte_next         = m_byte_reg;
        m_len_next          = m_len_reg;
        m_trunc_next        = m_trunc_reg;
        m_end_next          = m_end_reg;
        m_last_next         = m_last_reg;
        held_ctrl           = '0;
        rem_after           = 1'b0;

        // capacity write, clamped to the legal range
        if (cfg_we) begin
            if (cfg_wdata == '0) begin
                cap_next = ckf_pkg::CAP_W'(1);
            end else if (cfg_wdata > ckf_pkg::CAP_W'(ckf_pkg::MAX_CAPACITY)) begin
                cap_next = ckf_pkg::CAP_W'(ckf_pkg::MAX_CAPACITY);
            end else begin
                cap_next = cfg_wdata;
            end
        end

        if (out_free) begin
            m_valid_next = 1'b0;
        end

        // sequencer: one step of the emission plan per cycle while the output is free
        if (step_fire) begin
            if (byte_step) begin
                if (space_pend_reg) begin
                    space_pend_next = 1'b0;
                end else if (rel_cnt_reg != '0) begin
                    rel_cnt_next    = rel_cnt_reg - ckf_pkg::KCNT_W'(1);
                    held_ctrl.shift = 1'b1;
                end else begin
                    tail_byte_pend_next = 1'b0;
                end
                rem_after = space_pend_next || (rel_cnt_next != '0)
                            || tail_byte_pend_next || tail_end_pend_reg;
                if (room) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = step_byte;
                    m_end_next   = 1'b0;
                    m_len_next   = written_reg + ckf_pkg::LEN_W'(1);
                    m_trunc_next = trunc_after;
                    m_last_next  = !rem_after || (trunc_after && !tail_end_pend_reg);
                    written_next = written_reg + ckf_pkg::LEN_W'(1);
                    if (trunc_after) begin
                        // buffer full: remaining bytes go nowhere
                        space_pend_next     = 1'b0;
                        rel_cnt_next        = '0;
                        tail_byte_pend_next = 1'b0;
                    end
                end else begin
                    space_pend_next     = 1'b0;
                    rel_cnt_next        = '0;
                    tail_byte_pend_next = 1'b0;
                end
            end else begin
                // end of line word
                m_valid_next       = 1'b1;
                m_byte_next        = ckf_pkg::CHAR_NUL;
                m_end_next         = 1'b1;
                m_len_next         = written_reg;
                m_trunc_next       = trunc_now;
                m_last_next        = 1'b1;
                written_next       = '0;
                tail_end_pend_next = 1'b0;
            end
        end

        // decode of an accepted byte into the emission plan
        if (s_fire) begin
            tail_byte_next = s_tdata;
            if (s_tdata == ckf_pkg::CHAR_NUL) begin
                if (phase_reg == PH_HOLD) begin
                    space_pend_next = (written_reg != '0);
                    rel_cnt_next    = kcnt_reg;
                end
                tail_end_pend_next = 1'b1;
                phase_next         = PH_BETWEEN;
                kcnt_next          = '0;
            end else if (is_ws) begin
                if (phase_reg == PH_HOLD) begin
                    space_pend_next = (written_reg != '0);
                    rel_cnt_next    = kcnt_reg;
                end
                phase_next = PH_BETWEEN;
                kcnt_next  = '0;
            end else if (room) begin
                unique case (phase_reg)
                    PH_BETWEEN: begin
                        if (s_tdata == ckf_pkg::KEY_TEXT[0]) begin
                            held_ctrl.load = 1'b1;
                            held_ctrl.idx  = '0;
                            kcnt_next      = ckf_pkg::KCNT_W'(1);
                            phase_next     = PH_HOLD;
                        end else begin
                            space_pend_next     = (written_reg != '0);
                            tail_byte_pend_next = 1'b1;
                            phase_next          = PH_PASS;
                        end
                    end
                    PH_HOLD: begin
                        if (key_hit) begin
                            if (kcnt_reg == ckf_pkg::KCNT_W'(ckf_pkg::KEY_LENGTH - 1)) begin
                                phase_next = PH_DROP;
                                kcnt_next  = '0;
                            end else begin
                                held_ctrl.load = 1'b1;
                                held_ctrl.idx  = ckf_pkg::IDX_W'(kcnt_reg);
                                kcnt_next      = kcnt_reg + ckf_pkg::KCNT_W'(1);
                            end
                        end else begin
                            space_pend_next     = (written_reg != '0);
                            rel_cnt_next        = kcnt_reg;
                            tail_byte_pend_next = 1'b1;
                            kcnt_next           = '0;
                            phase_next          = PH_PASS;
                        end
                    end
                    PH_PASS: begin
                        tail_byte_pend_next = 1'b1;
                    end
                    PH_DROP: begin
                        phase_next = PH_DROP;
                    end
                    default: begin
                        phase_next = PH_BETWEEN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_BETWEEN;
            kcnt_reg           <= '0;
            written_reg        <= '0;
            cap_reg            <= ckf_pkg::CAP_W'(ckf_pkg::MAX_CAPACITY);
            space_pend_reg     <= 1'b0;
            rel_cnt_reg        <= '0;
            tail_byte_pend_reg <= 1'b0;
            tail_end_pend_reg  <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            phase_reg          <= phase_next;
            kcnt_reg           <= kcnt_next;
            written_reg        <= written_next;
            cap_reg            <= cap_next;
            space_pend_reg     <= space_pend_next;
            rel_cnt_reg        <= rel_cnt_next;
            tail_byte_pend_reg <= tail_byte_pend_next;
            tail_end_pend_reg  <= tail_end_pend_next;
            m_valid_reg        <= m_valid_next;
        end
        // payload, no reset needed
        tail_byte_reg <= tail_byte_next;
        m_byte_reg    <= m_byte_next;
        m_len_reg     <= m_len_next;
        m_trunc_reg   <= m_trunc_next;
        m_end_reg     <= m_end_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_trunc_reg, m_len_reg, m_byte_reg};
    assign m_tuser  = m_end_reg;
    assign m_tlast  = m_last_reg;

endmodule

### rtl/ckf_checker.sv
// ----------------------------------------------------------------------------
// ckf_checker: port-level checks of the key token filter
// watches the result stream and input readiness, bound to the top level
// ----------------------------------------------------------------------------
module ckf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // end word closes its run and carries a zero byte
    a_end_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == 8'h00))
        else $error("end word not last or byte nonzero");

    // a data word always counts at least itself
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[17:8] != 10'd0))
        else $error("data word with zero length");

    // no new byte taken while a run is still being sent
    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a run");

    // stalled word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result word changed under stall");

endmodule

bind cmdline_key_token_filter ckf_checker u_ckf_checker (.*);

### bench/ckf_line_checker.sv
// ----------------------------------------------------------------------------
// ckf_line_checker: result predictor and scoreboard for the key token filter
// watches the capacity writes and both streams, predicts the filtered words
// of every accepted byte and compares them in order with the result stream
// ----------------------------------------------------------------------------
module ckf_line_checker
    import ckf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [23:0]      m_tdata,
    input  logic             m_tuser,
    input  logic             m_tlast,
    output int               pending,
    output int               errors
);

    typedef enum logic [1:0] {
        TOK_GAP,
        TOK_HELD,
        TOK_KEPT,
        TOK_DROPPED
    } tok_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              at_end;
        logic [LEN_W-1:0]  length;
        logic              full;
        logic              last;
    } filt_word_t;

    localparam int PRINT_CAP = 100;

    logic [CAP_W-1:0]  capacity;
    tok_state_t        tok_state;
    int                key_hits;
    logic [BYTE_W-1:0] prefix [HELD_DEPTH];
    int                written;
    filt_word_t        due_q [$];
    int                err_count = 0;
    int                due_count = 0;

    assign pending = due_count;
    assign errors  = err_count;

    task automatic report(input string msg);
        err_count++;
        // keep the log short when the block is badly broken
        if (err_count <= PRINT_CAP)
            $display("mismatch: %s", msg);
    endtask

    function automatic int room_limit();
        int c = capacity;
        if (c == 0)
            c = 1;
        if (c > MAX_CAPACITY)
            c = MAX_CAPACITY;
        return c;
    endfunction

    function automatic void note_word(input logic [BYTE_W-1:0] ch, input logic at_end);
        filt_word_t w;
        w.ch     = ch;
        w.at_end = at_end;
        w.length = written[LEN_W-1:0];
        w.full   = (written + 1 == room_limit());
        w.last   = 1'b0;
        due_q.push_back(w);
    endfunction

    function automatic void emit_char(input logic [BYTE_W-1:0] ch);
        if (written + 1 < room_limit()) begin
            written++;
            note_word(ch, 1'b0);
        end
    endfunction

    // separating space only after something was written
    function automatic void open_token();
        if (written != 0)
            emit_char(CHAR_SPACE);
    endfunction

    function automatic void flush_prefix();
        open_token();
        for (int i = 0; i < key_hits; i++)
            emit_char(prefix[i]);
        key_hits = 0;
    endfunction

    function automatic void predict_byte(input logic [BYTE_W-1:0] b);
        int         prior_cnt;
        filt_word_t w;
        prior_cnt = due_q.size();
        if (b == CHAR_NUL) begin
            if (tok_state == TOK_HELD)
                flush_prefix();
            note_word(CHAR_NUL, 1'b1);
            tok_state = TOK_GAP;
            key_hits  = 0;
            written   = 0;
        end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
            if (tok_state == TOK_HELD)
                flush_prefix();
            tok_state = TOK_GAP;
            key_hits  = 0;
        end else if (written + 1 < room_limit()) begin
            case (tok_state)
                TOK_GAP: begin
                    if (b == KEY_TEXT[0]) begin
                        prefix[0] = b;
                        key_hits  = 1;
                        tok_state = TOK_HELD;
                    end else begin
                        tok_state = TOK_KEPT;
                        open_token();
                        emit_char(b);
                    end
                end
                TOK_HELD: begin
                    if (b == KEY_TEXT[key_hits]) begin
                        if (key_hits + 1 >= KEY_LENGTH) begin
                            tok_state = TOK_DROPPED;
                            key_hits  = 0;
                        end else begin
                            prefix[key_hits] = b;
                            key_hits++;
                        end
                    end else begin
                        flush_prefix();
                        emit_char(b);
                        tok_state = TOK_KEPT;
                    end
                end
                TOK_KEPT: emit_char(b);
                default: ;
            endcase
        end
        if (due_q.size() > prior_cnt) begin
            w      = due_q.pop_back();
            w.last = 1'b1;
            due_q.push_back(w);
        end
    endfunction

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic match_word();
        filt_word_t got;
        filt_word_t want;
        got = {m_tdata[7:0], m_tuser, m_tdata[17:8], m_tdata[18], m_tlast};
        if (due_q.size() == 0) begin
            report($sformatf("unexpected word %h", got));
        end else begin
            want = due_q.pop_front();
            check_field("out_byte", got.ch, want.ch);
            check_field("is_end", got.at_end, want.at_end);
            check_field("out_length", got.length, want.length);
            check_field("truncated", got.full, want.full);
            check_field("last_of_run", got.last, want.last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            capacity  = 11'(MAX_CAPACITY);
            tok_state = TOK_GAP;
            key_hits  = 0;
            written   = 0;
            due_q.delete();
        end else begin
            if (cfg_we)
                capacity = cfg_wdata;
            // predict before comparing so a same-edge word never misses its entry
            if (s_tvalid && s_tready)
                predict_byte(s_tdata);
            if (m_tvalid && m_tready)
                match_word();
        end
        due_count = due_q.size();
    end

endmodule

### bench/tb_cmdline_key_token_filter.sv
// ----------------------------------------------------------------------------
// tb_cmdline_key_token_filter: stimulus and verdict for the key token filter
// sends directed and random command lines under several capacities, with
// random gaps on both streams and one long result stall; the line checker
// predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_cmdline_key_token_filter;
    import ckf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 80;
    localparam int IDLE_PCT      = 14;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_TOKEN    = 60;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic [7:0]       s_tdata   = '0;
    logic             m_tready  = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic [23:0]      m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    int pending;
    int errors;
    int cycles = 0;

    // steady: no gaps on either side; hold_request: start the long result stall
    bit steady       = 1'b0;
    bit hold_request = 1'b0;
    bit hold_used    = 1'b0;
    int hold_left    = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    cmdline_key_token_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    ckf_line_checker line_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .pending   (pending),
        .errors    (errors)
    );

    // watchdog: a hung block or a lost word ends the run here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long stall so the block
    // fills up and has to push back on the byte stream
    always @(posedge aclk) begin
        if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(99) < IDLE_PCT) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one byte per word; random gaps ahead of it, then wait for the handshake
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++)
            send_byte(t[i]);
    endtask

    // drain: every predicted word back, then a margin for bytes that give none
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // any byte that is neither a separator nor the line end
    function automatic logic [7:0] token_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHAR_SPACE || c == CHAR_TAB);
        return c;
    endfunction

    function automatic logic [7:0] gap_char();
        return $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    // mostly well-formed lines: key tokens, key prefixes that break off or end
    // early, plain tokens; a few noise tokens that may hold whitespace
    task automatic send_random_line(output int sent);
        logic [7:0] line [$];
        logic [7:0] c;
        int         tokens;
        int         kind;
        int         n;
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 3)) line.push_back(gap_char());
        tokens = $urandom_range(1, 5);
        for (int k = 0; k < tokens; k++) begin
            if (k > 0)
                repeat ($urandom_range(1, 3)) line.push_back(gap_char());
            kind = $urandom_range(99);
            if (kind < 25) begin
                // whole key, then some dropped tail
                for (int i = 0; i < KEY_LENGTH; i++)
                    line.push_back(KEY_TEXT[i]);
                repeat ($urandom_range(0, 3)) line.push_back(token_char());
            end else if (kind < 50) begin
                // key prefix, either cut short or leaving the key
                n = $urandom_range(1, HELD_DEPTH);
                for (int i = 0; i < n; i++)
                    line.push_back(KEY_TEXT[i]);
                if ($urandom_range(1)) begin
                    do
                        c = token_char();
                    while (c == KEY_TEXT[n]);
                    line.push_back(c);
                    repeat ($urandom_range(0, 2)) line.push_back(token_char());
                end
            end else if (kind < 90) begin
                if ($urandom_range(3) == 0)
                    line.push_back(KEY_TEXT[0]);
                repeat ($urandom_range(1, 8)) line.push_back(token_char());
            end else begin
                repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(1, 255)));
            end
        end
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 3)) line.push_back(gap_char());
        line.push_back(CHAR_NUL);
        foreach (line[i])
            send_byte(line[i]);
        sent = line.size();
    endtask

    initial begin
        int sent;
        int total;
        int phase;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed line: leading whitespace, key token with tail, kept token,
        // prefix that leaves the key, 0xff byte, prefix ended by the line end
        set_capacity(11'(MAX_CAPACITY));
        send_text(" \ttpm.baseline=x a\ttpX");
        send_byte(8'hFF);
        send_text(" t");
        send_byte(CHAR_NUL);

        // capacity zero: nothing goes out, end word flags truncation
        set_capacity('0);
        send_text("ab");
        send_byte(CHAR_NUL);

        // clamped capacity and one long token, sent without any gaps
        set_capacity('1);
        steady <= 1'b1;
        for (int i = 0; i < LONG_TOKEN; i++)
            send_byte(token_char());
        send_byte(CHAR_NUL);
        steady <= 1'b0;

        // random lines under changing capacities; the first phase runs at full
        // capacity while the result side stalls
        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            if (phase == 0) begin
                set_capacity(11'(MAX_CAPACITY));
                hold_request <= 1'b1;
            end else begin
                case ($urandom_range(7))
                    0: set_capacity(11'd0);
                    1: set_capacity(11'd1);
                    2: set_capacity(11'd2);
                    3: set_capacity('1);
                    4: set_capacity(11'(MAX_CAPACITY));
                    5: set_capacity(11'($urandom_range(3, 12)));
                    default: set_capacity(11'($urandom_range(0, 2047)));
                endcase
            end
            repeat ($urandom_range(1, 2)) begin
                send_random_line(sent);
                total += sent;
            end
            phase++;
        end

        settle();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
